[hdl/obstacle_avoid_sequencer_top_defines.svh]
// assertion macros for the obstacle avoidance sequencer checker
// depends on nothing; included by the checker file only
`ifndef OBSTACLE_AVOID_SEQUENCER_TOP_DEFINES_SVH
`define OBSTACLE_AVOID_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define OAS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication, off while reset is high
`define OAS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication that also runs through reset
`define OAS_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

[hdl/oas_pkg.sv]
// shared types, codes and step table of the obstacle avoidance sequencer
// depends on nothing
`default_nettype none

package oas_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_ABORT = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   // drive codes
   localparam logic [2:0] DRV_STOP  = 3'd0;
   localparam logic [2:0] DRV_FWD   = 3'd1;
   localparam logic [2:0] DRV_BACK  = 3'd2;
   localparam logic [2:0] DRV_LEFT  = 3'd3;
   localparam logic [2:0] DRV_RIGHT = 3'd4;

   // number of entries in the step table
   localparam int MAX_STEPS = 12;

   localparam int STEP_W = 4;
   localparam int WAIT_W = 10;

   typedef struct packed {
      logic [1:0] cmd;
      logic       front_obstacle;
      logic       rear_obstacle;
      logic       side_front_left;
      logic       side_front_right;
      logic       side_rear_left;
      logic       side_rear_right;
   } req_word_type;

   typedef struct packed {
      logic [2:0] motor_command;
      logic       active;
      logic [3:0] step_number;
      logic       front_alert;
   } rsp_word_type;

   // action of each step
   function automatic logic [2:0] step_action(input logic [STEP_W-1:0] idx);
      logic [2:0] act;
      unique case (idx)
         4'd1:    act = DRV_BACK;
         4'd3:    act = DRV_LEFT;
         4'd5:    act = DRV_FWD;
         4'd7:    act = DRV_RIGHT;
         4'd9:    act = DRV_FWD;
         4'd11:   act = DRV_RIGHT;
         default: act = DRV_STOP;
      endcase
      return act;
   endfunction

   // duration of each step in ticks
   function automatic logic [WAIT_W-1:0] step_len(input logic [STEP_W-1:0] idx);
      logic [WAIT_W-1:0] len;
      unique case (idx)
         4'd0, 4'd1, 4'd3:                len = 10'd300;
         4'd2, 4'd4, 4'd6, 4'd8, 4'd10:   len = 10'd100;
         4'd5, 4'd7:                      len = 10'd500;
         4'd9:                            len = 10'd550;
         4'd11:                           len = 10'd400;
         default:                         len = 10'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

[hdl/oas_if.sv]
// valid/ready channel carrying one word of a given type
// depends on nothing; used with the word types of oas_pkg
`default_nettype none

interface oas_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

[hdl/oas_in_reg.sv]
// input register stage: takes a request word and holds it for the core
// depends on oas_pkg
`default_nettype none

module oas_in_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 up_valid,
   output logic                      up_ready,
   input  wire oas_pkg::req_word_type up_word,
   output logic                      dn_valid,
   input  wire logic                 dn_ready,
   output oas_pkg::req_word_type     dn_word
);

   logic                  valid_ff, valid_in;
   oas_pkg::req_word_type word_ff;

   // free when empty or when the held word moves on this cycle
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload load
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         word_ff <= up_word;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

`default_nettype wire

[hdl/oas_seq_core.sv]
// sequencer state, per-word step decision and result register
// depends on oas_pkg
`default_nettype none

module oas_seq_core #(
   parameter int STEP_COUNT = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire oas_pkg::req_word_type in_word,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output oas_pkg::rsp_word_type      out_word
);

   localparam logic [oas_pkg::STEP_W-1:0] STEP_LIM = oas_pkg::STEP_W'(STEP_COUNT);

   logic                          running_ff, running_in;
   logic [oas_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [oas_pkg::WAIT_W-1:0]    wait_ff, wait_in;
   logic [2:0]                    drive_ff, drive_in;
   logic                          out_valid_ff, out_valid_in;
   oas_pkg::rsp_word_type         out_word_ff;
   logic                          fire;

   logic [oas_pkg::WAIT_W-1:0]    wait_dec;
   logic [2:0]                    act;
   logic                          halt;
   logic [2:0]                    exec_drive;
   logic [oas_pkg::STEP_W-1:0]    step_base;
   logic [oas_pkg::STEP_W-1:0]    step_adv;

   assign in_ready = !out_valid_ff || out_ready;
   assign fire     = in_valid && in_ready;

   // action of the current step
   always_comb begin
      act        = oas_pkg::step_action(step_ff);
      halt       = 1'b0;
      exec_drive = drive_ff;
      if (step_ff < STEP_LIM) begin
         unique case (act)
            oas_pkg::DRV_BACK: begin
               if (in_word.rear_obstacle) halt = 1'b1;
               else exec_drive = oas_pkg::DRV_BACK;
            end
            oas_pkg::DRV_FWD: begin
               if (in_word.front_obstacle) halt = 1'b1;
               else exec_drive = oas_pkg::DRV_FWD;
            end
            oas_pkg::DRV_LEFT: begin
               priority if (in_word.side_front_left) begin
                  if (in_word.rear_obstacle) halt = 1'b1;
                  else exec_drive = oas_pkg::DRV_BACK;
               end else if (in_word.side_rear_right) begin
                  if (in_word.front_obstacle) halt = 1'b1;
                  else exec_drive = oas_pkg::DRV_FWD;
               end else begin
                  exec_drive = oas_pkg::DRV_LEFT;
               end
            end
            oas_pkg::DRV_RIGHT: begin
               priority if (in_word.side_front_right) begin
                  if (in_word.rear_obstacle) halt = 1'b1;
                  else exec_drive = oas_pkg::DRV_BACK;
               end else if (in_word.side_rear_left) begin
                  if (in_word.front_obstacle) halt = 1'b1;
                  else exec_drive = oas_pkg::DRV_FWD;
               end else begin
                  exec_drive = oas_pkg::DRV_RIGHT;
               end
            end
            default: begin
               exec_drive = oas_pkg::DRV_STOP;
            end
         endcase
      end
      if (halt) exec_drive = oas_pkg::DRV_STOP;
      step_base = halt ? '0 : step_ff;
      step_adv  = step_base + 4'd1;
      wait_dec  = (wait_ff != '0) ? wait_ff - 10'd1 : '0;
   end

   // next state per command
   always_comb begin
      running_in = running_ff;
      step_in    = step_ff;
      wait_in    = wait_ff;
      drive_in   = drive_ff;
      unique case (in_word.cmd)
         oas_pkg::CMD_START: begin
            running_in = 1'b1;
            step_in    = '0;
            wait_in    = '0;
         end
         oas_pkg::CMD_ABORT: begin
            running_in = 1'b0;
            step_in    = '0;
            drive_in   = oas_pkg::DRV_STOP;
         end
         oas_pkg::CMD_TICK: begin
            if (running_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  running_in = !halt;
                  drive_in   = exec_drive;
                  // step advance, also after an aborted step
                  if (step_adv >= STEP_LIM) begin
                     running_in = 1'b0;
                     step_in    = '0;
                     drive_in   = oas_pkg::DRV_STOP;
                  end else begin
                     step_in = step_adv;
                     wait_in = oas_pkg::step_len(step_adv);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in = in_ready ? in_valid : out_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         step_ff      <= '0;
         wait_ff      <= '0;
         drive_ff     <= oas_pkg::DRV_STOP;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            running_ff <= running_in;
            step_ff    <= step_in;
            wait_ff    <= wait_in;
            drive_ff   <= drive_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (fire) begin
         out_word_ff.motor_command <= drive_in;
         out_word_ff.active        <= running_in;
         out_word_ff.step_number   <= step_in;
         out_word_ff.front_alert   <= in_word.front_obstacle;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

`default_nettype wire

[hdl/obstacle_avoid_sequencer_top.sv]
// Obstacle avoidance sequencer: a request word (tick, start, abort or nop plus
// six obstacle flags) is taken into an input register, then the sequencer state
// is updated and one response word (held drive, active flag, next step index,
// front alert) is written into the result register. One word is accepted every
// cycle with no bubbles while the response side is ready. The rate is set by
// the state update loop in oas_seq_core, where the state registers feed back
// through the step logic. A request passes the input and result registers.
// STEP_COUNT (1 to 12) shortens the maneuver to its first steps.
// top level; depends on oas_pkg, oas_if, oas_in_reg and oas_seq_core
`default_nettype none

module obstacle_avoid_sequencer_top #(
   parameter int STEP_COUNT = 12
) (
   input wire logic clock,
   input wire logic reset,
   oas_if.sink      req_port,
   oas_if.source    rsp_port
);

   logic                  core_valid;
   logic                  core_ready;
   oas_pkg::req_word_type core_word;

   oas_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_port.valid),
      .up_ready (req_port.ready),
      .up_word  (req_port.word),
      .dn_valid (core_valid),
      .dn_ready (core_ready),
      .dn_word  (core_word)
   );

   oas_seq_core #(
      .STEP_COUNT (STEP_COUNT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_ready  (core_ready),
      .in_word   (core_word),
      .out_valid (rsp_port.valid),
      .out_ready (rsp_port.ready),
      .out_word  (rsp_port.word)
   );

endmodule

`default_nettype wire

[hdl/oas_checker.sv]
// port-level checks for the obstacle avoidance sequencer, bound to the top
// depends on oas_pkg and obstacle_avoid_sequencer_top_defines.svh
`default_nettype none

`include "obstacle_avoid_sequencer_top_defines.svh"

module oas_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire oas_pkg::rsp_word_type rsp_word
);

   // a stalled response holds
   `OAS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // the motor is stopped whenever the sequence is not running
   `OAS_ASSERT_IMP(a_idle_stop, clock, reset, rsp_valid && !rsp_word.active, rsp_word.motor_command == oas_pkg::DRV_STOP)

   // step index stays inside the table
   `OAS_ASSERT_IMP(a_step_range, clock, reset, rsp_valid, rsp_word.step_number < 4'd12)

   // nothing comes out right after reset
   `OAS_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind obstacle_avoid_sequencer_top oas_checker u_oas_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_port.valid),
   .rsp_ready (rsp_port.ready),
   .rsp_word  (rsp_port.word)
);

`default_nettype wire
